>>> hdl/pfll_pkg.sv
package pfll_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIV_STEPS = 64 + 2 * FRAC_BITS;
	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam int QDEPTH = 2;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_A = 3'd1;
	localparam logic [2:0] REG_B = 3'd2;
	localparam logic [2:0] REG_C = 3'd3;
	localparam logic [2:0] REG_D = 3'd4;

	localparam logic [1:0] MODE_LIN = 2'd0;
	localparam logic [1:0] MODE_QUAD = 2'd1;
	localparam logic [1:0] MODE_CUBIC = 2'd2;
	localparam logic [1:0] MODE_QUART = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] value;
		logic [30:0] sigma;
		logic last;
		logic sigma_zero;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_MUL, ST_RND, ST_SUM, ST_RES,
		ST_SQ, ST_DEN, ST_DIV, ST_ACC, ST_OUT
	} state_t;

endpackage

>>> hdl/pfll_if.sv
interface pfll_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] sample_x;
	logic signed [31:0] sample_value;
	logic [30:0] sample_sigma;
	logic last_point;
	modport source (output valid, sample_x, sample_value, sample_sigma, last_point, input ready);
	modport sink (input valid, sample_x, sample_value, sample_sigma, last_point, output ready);
endinterface

interface pfll_out_if;
	logic valid;
	logic ready;
	logic signed [63:0] log_likelihood;
	logic sigma_zero_seen;
	logic saturated;
	modport source (output valid, log_likelihood, sigma_zero_seen, saturated, input ready);
	modport sink (input valid, log_likelihood, sigma_zero_seen, saturated, output ready);
endinterface

>>> hdl/polynomial_fit_log_likelihood_core.sv
// A nonzero-sigma point reaches its sum update via load, a multiply and a round state per model
// multiply (1, 2 or 4 by mode), sum, residual, square, denominator and a divider of up to 96 steps;
// a zero-sigma point skips from load to accumulate. The result word is registered in ST_OUT.
// Throughput: one point per pass of the back sequencer; the bit-serial divider sets it.
// A two-word queue lets the front take points while the back is busy.
// Reset (arst_n low): config, sequencer state, queue count, sum and flags clear to zero; mode is linear.
module polynomial_fit_log_likelihood_core (
	input logic clk,
	input logic arst_n,
	pfll_in_if.sink samples,
	pfll_out_if.source results,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	pfll_pkg::cfg_t cfg_q;
	pfll_pkg::item_t head;
	logic head_valid;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfll_pkg::REG_MODE: cfg_q.mode <= cfg_data[1:0];
				pfll_pkg::REG_A: cfg_q.a <= cfg_data;
				pfll_pkg::REG_B: cfg_q.b <= cfg_data;
				pfll_pkg::REG_C: cfg_q.c <= cfg_data;
				pfll_pkg::REG_D: cfg_q.d <= cfg_data;
				default: ;
			endcase
		end
	end

	pfll_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.pop(pop),
		.head(head),
		.head_valid(head_valid)
	);

	pfll_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.results(results)
	);
endmodule

>>> hdl/pfll_front.sv
module pfll_front (
	input logic clk,
	input logic arst_n,
	pfll_in_if.sink samples,
	input logic pop,
	output pfll_pkg::item_t head,
	output logic head_valid
);
	pfll_pkg::item_t entry_q [pfll_pkg::QDEPTH];
	logic rd_q;
	logic wr_q;
	logic [1:0] count_q;
	logic push;
	pfll_pkg::item_t incoming;

	assign samples.ready = (count_q != 2'(pfll_pkg::QDEPTH));
	assign push = samples.valid && samples.ready;
	assign head_valid = (count_q != 2'd0);
	assign head = entry_q[rd_q];

	always_comb begin
		incoming.x = samples.sample_x;
		incoming.value = samples.sample_value;
		incoming.sigma = samples.sample_sigma;
		incoming.last = samples.last_point;
		incoming.sigma_zero = (samples.sample_sigma == 31'd0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'(pfll_pkg::QDEPTH))
		else $error("queue count overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count lost a push");
endmodule

>>> hdl/pfll_back.sv
module pfll_back (
	input logic clk,
	input logic arst_n,
	input pfll_pkg::cfg_t cfg,
	input pfll_pkg::item_t head,
	input logic head_valid,
	output logic pop,
	pfll_out_if.source results
);
	localparam logic [63:0] SUM_LIMIT = 64'h8000_0000_0000_0000;
	localparam logic signed [65:0] HALF = 66'sd1 <<< (pfll_pkg::FRAC_BITS - 1);
	localparam logic signed [32:0] I32_MAX = 33'sh0_7FFF_FFFF;
	localparam logic signed [32:0] I32_MIN = -33'sh0_8000_0000;

	pfll_pkg::state_t state_q, state_d;
	pfll_pkg::item_t item_q;
	logic signed [31:0] d_q, d2_q, t1_q, t3_q, tmp_q, mdl_q;
	logic [1:0] step_q;
	logic signed [63:0] prod_q;
	logic [31:0] mag_q;
	logic [63:0] r2_q, num_q, rem_q, sum_q;
	logic [62:0] den_q, quo_q;
	logic [pfll_pkg::CNT_W-1:0] cnt_q;
	logic fail_q, zf_q, ovf_q;
	logic out_v_q;
	logic signed [63:0] out_ll_q;
	logic out_zf_q, out_ovf_q;

	logic signed [32:0] opa, opb;
	logic signed [65:0] mul_p;
	logic signed [65:0] rnd_full;
	logic signed [31:0] rnd_sat;
	logic rnd_ovf;
	logic [1:0] last_step;
	logic signed [32:0] diff;
	logic signed [33:0] msum;
	logic signed [32:0] resid;
	logic [63:0] rem_n;
	logic div_ge;
	logic [63:0] headroom;
	logic out_free;

	assign mul_p = opa * opb;
	assign rnd_full = ($signed({{2{prod_q[63]}}, prod_q}) + HALF) >>> pfll_pkg::FRAC_BITS;
	assign rnd_ovf = (rnd_full > 66'(I32_MAX)) || (rnd_full < 66'(I32_MIN));
	assign rnd_sat = (rnd_full > 66'(I32_MAX)) ? 32'sh7FFF_FFFF :
		(rnd_full < 66'(I32_MIN)) ? 32'sh8000_0000 : rnd_full[31:0];
	assign last_step = (cfg.mode == pfll_pkg::MODE_LIN) ? 2'd0 :
		(cfg.mode == pfll_pkg::MODE_QUAD) ? 2'd1 : 2'd3;
	assign diff = 33'(item_q.x) - 33'(cfg.c);
	assign msum = ((cfg.mode == pfll_pkg::MODE_LIN) ? 34'(cfg.b) : 34'(cfg.a))
		+ 34'(t1_q) + 34'(t3_q);
	assign resid = 33'(item_q.value) - 33'(mdl_q);
	assign rem_n = {rem_q[62:0], num_q[63]};
	assign div_ge = (rem_n >= {1'b0, den_q});
	assign headroom = SUM_LIMIT - sum_q;
	assign out_free = !out_v_q || results.ready;
	assign pop = (state_q == pfll_pkg::ST_IDLE) && head_valid;

	assign results.valid = out_v_q;
	assign results.log_likelihood = out_ll_q;
	assign results.sigma_zero_seen = out_zf_q;
	assign results.saturated = out_ovf_q;

	always_comb begin
		opa = 33'sd0;
		opb = 33'sd0;
		if (state_q == pfll_pkg::ST_SQ) begin
			opa = $signed({1'b0, mag_q});
			opb = $signed({1'b0, mag_q});
		end else if (state_q == pfll_pkg::ST_DEN) begin
			opa = $signed({2'b00, item_q.sigma});
			opb = $signed({2'b00, item_q.sigma});
		end else begin
			case (step_q)
				2'd0: begin
					opa = (cfg.mode == pfll_pkg::MODE_LIN) ? 33'(cfg.a) : 33'(d_q);
					opb = 33'(d_q);
				end
				2'd1: begin
					opa = 33'(cfg.b);
					opb = 33'(d2_q);
				end
				2'd2: begin
					opa = 33'(d2_q);
					opb = (cfg.mode == pfll_pkg::MODE_QUART) ? 33'(d2_q) : 33'(d_q);
				end
				default: begin
					opa = (cfg.mode == pfll_pkg::MODE_QUART) ? 33'(cfg.c) : 33'(cfg.d);
					opb = 33'(tmp_q);
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfll_pkg::ST_IDLE: if (head_valid) state_d = pfll_pkg::ST_LOAD;
			pfll_pkg::ST_LOAD: state_d = item_q.sigma_zero ? pfll_pkg::ST_ACC : pfll_pkg::ST_MUL;
			pfll_pkg::ST_MUL: state_d = pfll_pkg::ST_RND;
			pfll_pkg::ST_RND: state_d = (step_q == last_step) ? pfll_pkg::ST_SUM : pfll_pkg::ST_MUL;
			pfll_pkg::ST_SUM: state_d = pfll_pkg::ST_RES;
			pfll_pkg::ST_RES: state_d = pfll_pkg::ST_SQ;
			pfll_pkg::ST_SQ: state_d = pfll_pkg::ST_DEN;
			pfll_pkg::ST_DEN: state_d = pfll_pkg::ST_DIV;
			pfll_pkg::ST_DIV: begin
				if (quo_q[62] || cnt_q == pfll_pkg::CNT_W'(pfll_pkg::DIV_STEPS - 1))
					state_d = pfll_pkg::ST_ACC;
			end
			pfll_pkg::ST_ACC: state_d = item_q.last ? pfll_pkg::ST_OUT : pfll_pkg::ST_IDLE;
			pfll_pkg::ST_OUT: if (out_free) state_d = pfll_pkg::ST_IDLE;
			default: state_d = pfll_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfll_pkg::ST_IDLE;
			sum_q <= 64'd0;
			zf_q <= 1'b0;
			ovf_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (results.ready && !(state_q == pfll_pkg::ST_OUT && out_free)) out_v_q <= 1'b0;
			case (state_q)
				pfll_pkg::ST_LOAD: begin
					if (item_q.sigma_zero) zf_q <= 1'b1;
					else if ((cfg.mode == pfll_pkg::MODE_QUAD || cfg.mode == pfll_pkg::MODE_CUBIC)
						&& (diff > I32_MAX || diff < I32_MIN)) ovf_q <= 1'b1;
				end
				pfll_pkg::ST_RND: if (rnd_ovf) ovf_q <= 1'b1;
				pfll_pkg::ST_SUM: begin
					if (msum > 34'(I32_MAX) || msum < 34'(I32_MIN)) ovf_q <= 1'b1;
				end
				pfll_pkg::ST_ACC: begin
					if (!item_q.sigma_zero) begin
						if (fail_q || {1'b0, quo_q} > headroom) begin
							sum_q <= SUM_LIMIT;
							ovf_q <= 1'b1;
						end else begin
							sum_q <= sum_q + {1'b0, quo_q};
						end
					end
				end
				pfll_pkg::ST_OUT: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						sum_q <= 64'd0;
						zf_q <= 1'b0;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) item_q <= head;
		case (state_q)
			pfll_pkg::ST_LOAD: begin
				step_q <= 2'd0;
				t3_q <= 32'sd0;
				if (cfg.mode == pfll_pkg::MODE_QUAD || cfg.mode == pfll_pkg::MODE_CUBIC)
					d_q <= (diff > I32_MAX) ? 32'sh7FFF_FFFF :
						(diff < I32_MIN) ? 32'sh8000_0000 : diff[31:0];
				else
					d_q <= item_q.x;
			end
			pfll_pkg::ST_MUL: prod_q <= mul_p[63:0];
			pfll_pkg::ST_RND: begin
				step_q <= step_q + 2'd1;
				case (step_q)
					2'd0: begin
						if (cfg.mode == pfll_pkg::MODE_LIN) t1_q <= rnd_sat;
						else d2_q <= rnd_sat;
					end
					2'd1: t1_q <= rnd_sat;
					2'd2: tmp_q <= rnd_sat;
					default: t3_q <= rnd_sat;
				endcase
			end
			pfll_pkg::ST_SUM: begin
				mdl_q <= (msum > 34'(I32_MAX)) ? 32'sh7FFF_FFFF :
					(msum < 34'(I32_MIN)) ? 32'sh8000_0000 : msum[31:0];
			end
			pfll_pkg::ST_RES: mag_q <= resid[32] ? 32'(-resid) : resid[31:0];
			pfll_pkg::ST_SQ: r2_q <= mul_p[63:0];
			pfll_pkg::ST_DEN: begin
				den_q <= {mul_p[61:0], 1'b0};
				num_q <= r2_q;
				rem_q <= 64'd0;
				quo_q <= 63'd0;
				cnt_q <= '0;
				fail_q <= 1'b0;
			end
			pfll_pkg::ST_DIV: begin
				if (quo_q[62]) begin
					fail_q <= 1'b1;
				end else begin
					num_q <= {num_q[62:0], 1'b0};
					rem_q <= div_ge ? rem_n - {1'b0, den_q} : rem_n;
					quo_q <= {quo_q[61:0], div_ge};
					cnt_q <= cnt_q + pfll_pkg::CNT_W'(1);
				end
			end
			pfll_pkg::ST_OUT: begin
				if (out_free) begin
					out_ll_q <= $signed(64'd0 - sum_q);
					out_zf_q <= zf_q;
					out_ovf_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) sum_q <= SUM_LIMIT)
		else $error("sum magnitude beyond limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.log_likelihood[63] || results.log_likelihood == 64'sd0))
		else $error("positive log-likelihood");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfll_pkg::ST_DIV |-> cnt_q < pfll_pkg::CNT_W'(pfll_pkg::DIV_STEPS))
		else $error("divider ran past its step count");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfll_pkg::ST_OUT && out_free |=> out_v_q && sum_q == 64'd0)
		else $error("result not issued or sum not cleared");
endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] value;
		logic [30:0] sigma;
		logic last;
	} point_t;

	typedef struct {
		logic signed [63:0] log_likelihood;
		logic sigma_zero_seen;
		logic saturated;
	} fit_result_t;

	localparam logic [63:0] SUM_CEIL = 64'h8000_0000_0000_0000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	pfll_in_if smp ();
	pfll_out_if res ();

	polynomial_fit_log_likelihood_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(smp),
		.results(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	point_t pending_points[$];
	fit_result_t expected_fits[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_go = 0;
	bit hold_seen = 0;
	int hold_cnt = 0;

	pfll_pkg::cfg_t model_cfg;
	logic [63:0] chi_mag;
	bit zero_flag;
	bit ovf_flag;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) begin
			ovf_flag = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf_flag = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		longint p;
		p = a * b;
		return clamp32((p + (64'sd1 <<< (pfll_pkg::FRAC_BITS - 1))) >>> pfll_pkg::FRAC_BITS);
	endfunction

	function automatic longint curve_at(longint x);
		longint a, b, c, d, dx, dx2, x2;
		a = model_cfg.a;
		b = model_cfg.b;
		c = model_cfg.c;
		d = model_cfg.d;
		case (model_cfg.mode)
			pfll_pkg::MODE_LIN: return clamp32(fx_mul(a, x) + b);
			pfll_pkg::MODE_QUAD: begin
				dx = clamp32(x - c);
				dx2 = fx_mul(dx, dx);
				return clamp32(a + fx_mul(b, dx2));
			end
			pfll_pkg::MODE_CUBIC: begin
				dx = clamp32(x - c);
				dx2 = fx_mul(dx, dx);
				return clamp32(a + fx_mul(b, dx2) + fx_mul(d, fx_mul(dx2, dx)));
			end
			default: begin
				x2 = fx_mul(x, x);
				return clamp32(a + fx_mul(b, x2) + fx_mul(c, fx_mul(x2, x2)));
			end
		endcase
	endfunction

	function automatic bit chi_term(logic [63:0] num, logic [63:0] den, output logic [63:0] q);
		logic [63:0] rem;
		rem = 0;
		q = 0;
		for (int i = 0; i < pfll_pkg::DIV_STEPS; i++) begin
			rem = {rem[62:0], (i < 64) ? num[63 - i] : 1'b0};
			if (q >= 64'h4000_0000_0000_0000)
				return 0;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return 1;
	endfunction

	task automatic accumulate_point(point_t pt);
		longint r;
		logic [63:0] mag, r2, den, term;
		fit_result_t fr;
		if (pt.sigma == 0) begin
			zero_flag = 1;
		end else begin
			r = longint'(pt.value) - curve_at(longint'(pt.x));
			mag = (r < 0) ? -r : r;
			r2 = mag * mag;
			den = 64'd2 * pt.sigma * pt.sigma;
			if (!chi_term(r2, den, term) || term > SUM_CEIL - chi_mag) begin
				chi_mag = SUM_CEIL;
				ovf_flag = 1;
			end else begin
				chi_mag = chi_mag + term;
			end
		end
		if (pt.last) begin
			fr.log_likelihood = 64'd0 - chi_mag;
			fr.sigma_zero_seen = zero_flag;
			fr.saturated = ovf_flag;
			expected_fits = {expected_fits, fr};
			chi_mag = 0;
			zero_flag = 0;
			ovf_flag = 0;
		end
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		point_t pt;
		bit offer;
		if (!arst_n) begin
			smp.valid <= 0;
			smp.sample_x <= 0;
			smp.sample_value <= 0;
			smp.sample_sigma <= 0;
			smp.last_point <= 0;
		end else begin
			if (smp.valid && !smp.ready) begin
				offer = 1;
			end else begin
				if (smp.valid && smp.ready) begin
					accumulate_point(pending_points.pop_front());
				end
				offer = pending_points.size() > 0 && ($urandom_range(99) >= send_idle_pct);
			end
			if (offer) begin
				pt = pending_points[0];
				smp.sample_x <= pt.x;
				smp.sample_value <= pt.value;
				smp.sample_sigma <= pt.sigma;
				smp.last_point <= pt.last;
			end
			smp.valid <= offer;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 0;
			hold_cnt <= 0;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_cnt <= 900;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		fit_result_t fr;
		if (!arst_n) begin
			res.ready <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_fits.size() == 0) begin
					$error("unexpected result word ll=%h", res.log_likelihood);
					errors++;
				end else begin
					fr = expected_fits.pop_front();
					if (res.log_likelihood !== fr.log_likelihood) begin
						$error("log_likelihood expected %h actual %h",
							fr.log_likelihood, res.log_likelihood);
						errors++;
					end
					if (res.sigma_zero_seen !== fr.sigma_zero_seen) begin
						$error("sigma_zero_seen expected %b actual %b",
							fr.sigma_zero_seen, res.sigma_zero_seen);
						errors++;
					end
					if (res.saturated !== fr.saturated) begin
						$error("saturated expected %b actual %b",
							fr.saturated, res.saturated);
						errors++;
					end
				end
			end
			if (hold_go != hold_seen || hold_cnt > 0)
				res.ready <= 0;
			else
				res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			pfll_pkg::REG_MODE: model_cfg.mode = data[1:0];
			pfll_pkg::REG_A: model_cfg.a = data;
			pfll_pkg::REG_B: model_cfg.b = data;
			pfll_pkg::REG_C: model_cfg.c = data;
			pfll_pkg::REG_D: model_cfg.d = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic wait_drained();
		while (pending_points.size() != 0 || expected_fits.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_q(int kind);
		case (kind)
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_field();
		int k;
		k = $urandom_range(15);
		return rand_q(k == 0 ? 0 : k == 1 ? 1 : k < 6 ? 2 : 3);
	endfunction

	function automatic logic [30:0] rand_sigma();
		int k;
		k = $urandom_range(15);
		if (k == 0)
			return 31'd0;
		if (k < 3)
			return 31'($urandom);
		if (k == 3)
			return 31'h7FFF_FFFF;
		return 31'($urandom_range(32'h0002_0000, 1));
	endfunction

	task automatic add_point(logic [31:0] x, logic [31:0] v, logic [30:0] s, logic l);
		point_t pt;
		pt.x = x;
		pt.value = v;
		pt.sigma = s;
		pt.last = l;
		pending_points = {pending_points, pt};
	endtask

	initial begin
		int n;
		int len;
		model_cfg = '0;
		chi_mag = 0;
		zero_flag = 0;
		ovf_flag = 0;
		cfg_we = 0;
		cfg_index = pfll_pkg::REG_MODE;
		cfg_data = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 0;
		@(negedge clk);
		arst_n = 1;

		send_idle_pct = 28;
		recv_idle_pct = 77;
		add_point(32'h0001_0000, 32'h0003_0000, 31'h0001_0000, 0);
		add_point(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 0);
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_0001, 1);
		add_point(32'h0000_0000, 32'h0000_0000, 31'h0000_0000, 1);
		add_point(32'h0002_0000, 32'h7FFF_FFFF, 31'h0000_0001, 0);
		add_point(32'h0002_0000, 32'h0001_0000, 31'h0000_0000, 1);
		for (int i = 0; i < 5; i++)
			add_point(32'h0000_0000, 32'h4000_0000, 31'h0000_0100, i == 4);
		wait_drained();

		for (int ph = 0; ph < 36; ph++) begin
			if (ph == 12) begin
				send_idle_pct = 77;
				recv_idle_pct = 28;
			end else if (ph == 24) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(pfll_pkg::REG_MODE, 32'(ph % 4));
			write_reg(pfll_pkg::REG_A, rand_q(ph < 4 ? 0 : ph < 8 ? 1 : ph % 5 == 0 ? 2 : 3));
			write_reg(pfll_pkg::REG_B, rand_q(ph < 4 ? 0 : ph < 8 ? 1 : ph % 7 == 0 ? 2 : 3));
			write_reg(pfll_pkg::REG_C, rand_q(ph < 4 ? 1 : ph < 8 ? 0 : ph % 6 == 0 ? 2 : 3));
			write_reg(pfll_pkg::REG_D, rand_q(ph < 4 ? 0 : ph < 8 ? 1 : ph % 9 == 0 ? 2 : 3));
			if (ph == 5 || ph == 30)
				hold_go = ~hold_go;
			n = 0;
			while (n < 46) begin
				len = $urandom_range(6, 1);
				for (int j = 0; j < len; j++)
					add_point(rand_field(), rand_field(), rand_sigma(), j == len - 1);
				n += len;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
hdl/pfll_pkg.sv
hdl/pfll_if.sv
hdl/pfll_front.sv
hdl/pfll_back.sv
hdl/polynomial_fit_log_likelihood_core.sv
verif/testbench.sv
